// ----- hdl/clib_pkg.sv -----
// Shared types and constants for the console line input buffer.
package clib_pkg;

  localparam int KEY_W   = 8;
  localparam int KIND_W  = 2;
  localparam int LINES_W = 12;

  localparam logic [LINES_W-1:0] LINES_MAX = 12'd4095;

  localparam logic [KEY_W-1:0] CH_BS  = 8'h08;
  localparam logic [KEY_W-1:0] CH_TAB = 8'h09;
  localparam logic [KEY_W-1:0] CH_NL  = 8'h0A;
  localparam logic [KEY_W-1:0] CH_SP  = 8'h20;

  localparam logic [KIND_W-1:0] KIND_ECHO      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOT_READY = 2'd2;

  localparam logic OP_PRESS = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_ECHO_ENABLE = 1'b0;
  localparam logic REG_LINE_MODE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
    logic last_beat;
  } dp_stat_t;

endpackage

// ----- hdl/clib_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module clib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/clib_ctrl.sv -----
// Controller state machine: accept, execute, then emit the result beats.
module clib_ctrl import clib_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = stat.has_result ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_beat) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.emit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- hdl/clib_dp.sv -----
// Datapath: ring pointers, line count, ring store, echo sequencer and output register.
module clib_dp import clib_pkg::*; #(
  parameter int RING_DEPTH       = 4096,
  parameter int TAB_ERASE_REPEAT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               in_op,
  input  logic [KEY_W-1:0]   in_key,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_kind,
  output logic [KEY_W-1:0]   out_data,
  output logic               out_last,
  output logic [LINES_W-1:0] out_lines_waiting
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int REP_W = (TAB_ERASE_REPEAT > 1) ? $clog2(TAB_ERASE_REPEAT) : 1;
  localparam int CNT_W = (PTR_W > LINES_W) ? PTR_W : LINES_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [REP_W-1:0] REP_TAB_LAST = REP_W'(TAB_ERASE_REPEAT - 1);

  localparam logic [1:0] PH_BS1   = 2'd0;
  localparam logic [1:0] PH_SPACE = 2'd1;
  localparam logic [1:0] PH_BS2   = 2'd2;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  lines_r, lines_nxt;
  logic              echo_en_r, echo_en_nxt;
  logic              line_mode_r, line_mode_nxt;
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic              erase_r, erase_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [REP_W-1:0]  rep_last_r, rep_last_nxt;
  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [KEY_W-1:0]  res_data_r, res_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [KEY_W-1:0]  out_data_r;
  logic              out_last_r;
  logic [LINES_W-1:0] out_lines_r;

  logic [PTR_W-1:0]  wr_inc, wr_inc2, wr_dec, rd_inc, ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;
  logic              ram_we;
  logic              empty, read_ok, has_result;
  logic [KIND_W-1:0] beat_kind;
  logic [KEY_W-1:0]  beat_data;
  logic [CNT_W-1:0]  lines_ext;
  logic [LINES_W-1:0] lines_sat;

  assign wr_inc  = ptr_inc(wr_ptr_r);
  assign wr_inc2 = ptr_inc(wr_inc);
  assign wr_dec  = ptr_dec(wr_ptr_r);
  assign rd_inc  = ptr_inc(rd_ptr_r);
  assign empty   = (rd_ptr_r == wr_ptr_r);
  assign read_ok = !empty && (!line_mode_r || (lines_r != '0));

  // A read looks at the head; a key press looks at the last stored byte for erase.
  assign ram_raddr = (in_op == OP_READ) ? rd_ptr_r : wr_dec;

  clib_ram #(
    .WIDTH(KEY_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata(key_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    lines_nxt     = lines_r;
    echo_en_nxt   = echo_en_r;
    line_mode_nxt = line_mode_r;
    erase_nxt     = erase_r;
    phase_nxt     = phase_r;
    rep_nxt       = rep_r;
    rep_last_nxt  = rep_last_r;
    res_kind_nxt  = res_kind_r;
    res_data_nxt  = res_data_r;
    ram_we        = 1'b0;
    has_result    = 1'b0;

    if (cmd.exec) begin
      phase_nxt = PH_BS1;
      rep_nxt   = '0;
      if (op_r == OP_PRESS) begin
        if (key_r == CH_BS && echo_en_r) begin
          if (!empty && ram_rdata != CH_NL) begin
            wr_ptr_nxt   = wr_dec;
            erase_nxt    = 1'b1;
            rep_last_nxt = (ram_rdata == CH_TAB) ? REP_TAB_LAST : '0;
            has_result   = 1'b1;
          end
        end else if (wr_inc != rd_ptr_r && !(wr_inc2 == rd_ptr_r && key_r != CH_NL)) begin
          ram_we       = 1'b1;
          wr_ptr_nxt   = wr_inc;
          erase_nxt    = 1'b0;
          res_kind_nxt = KIND_ECHO;
          res_data_nxt = key_r;
          has_result   = echo_en_r;
          if (line_mode_r && key_r == CH_NL) lines_nxt = lines_r + 1'b1;
        end
      end else begin
        erase_nxt  = 1'b0;
        has_result = 1'b1;
        if (read_ok) begin
          rd_ptr_nxt   = rd_inc;
          res_kind_nxt = KIND_DATA;
          res_data_nxt = ram_rdata;
          if (line_mode_r && ram_rdata == CH_NL && lines_r != '0) begin
            lines_nxt = lines_r - 1'b1;
          end
        end else begin
          res_kind_nxt = KIND_NOT_READY;
          res_data_nxt = '0;
        end
      end
    end

    // Advance the erase sequence: backspace, space, backspace per repeat.
    if (cmd.emit && erase_r) begin
      if (phase_r == PH_BS2) begin
        phase_nxt = PH_BS1;
        rep_nxt   = rep_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end

    if (cfg_we) begin
      if (cfg_index == REG_ECHO_ENABLE) begin
        echo_en_nxt = cfg_data;
      end else begin
        line_mode_nxt = cfg_data;
        rd_ptr_nxt    = '0;
        wr_ptr_nxt    = '0;
        lines_nxt     = '0;
      end
    end
  end

  assign stat.has_result = has_result;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.last_beat  = !erase_r || (phase_r == PH_BS2 && rep_r == rep_last_r);

  assign beat_kind = erase_r ? KIND_ECHO : res_kind_r;
  assign beat_data = erase_r ? ((phase_r == PH_SPACE) ? CH_SP : CH_BS) : res_data_r;

  // Saturate the line count to the field width.
  assign lines_ext = CNT_W'(lines_r);
  assign lines_sat = (lines_ext > CNT_W'(LINES_MAX)) ? LINES_MAX : lines_ext[LINES_W-1:0];

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      lines_r     <= '0;
      echo_en_r   <= 1'b1;
      line_mode_r <= 1'b1;
      erase_r     <= 1'b0;
      phase_r     <= PH_BS1;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      lines_r     <= lines_nxt;
      echo_en_r   <= echo_en_nxt;
      line_mode_r <= line_mode_nxt;
      erase_r     <= erase_nxt;
      phase_r     <= phase_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
    rep_last_r <= rep_last_nxt;
    res_kind_r <= res_kind_nxt;
    res_data_r <= res_data_nxt;
    if (cmd.emit) begin
      out_kind_r  <= beat_kind;
      out_data_r  <= beat_data;
      out_last_r  <= stat.last_beat;
      out_lines_r <= lines_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_data          = out_data_r;
  assign out_last          = out_last_r;
  assign out_lines_waiting = out_lines_r;

endmodule

// ----- hdl/console_line_input_buffer.sv -----
// Top level of the console line input buffer.
// Console input ring with echo and line editing. Each beat on the input is a key press
// (in_op 0) or a read (in_op 1); items are handled one at a time. An item is accepted,
// then executed against the ring (the ring memory has a registered read port, so the byte
// at the head or the last stored byte is read while the item is accepted and is ready in
// the execute state), then its result beats go out one per cycle unless the output stalls:
// a plain key press gives 0 or 1 echo beat, a read gives exactly 1 beat, and a backspace
// erase gives 3 beats, or 3*TAB_ERASE_REPEAT beats when a tab is erased. The last result
// beat sits in the output register while the next item is accepted. Writing line_mode
// empties the ring.
module console_line_input_buffer import clib_pkg::*; #(
  parameter int RING_DEPTH       = 4096,
  parameter int TAB_ERASE_REPEAT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [KEY_W-1:0]   in_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_kind,
  output logic [KEY_W-1:0]   out_data,
  output logic               out_last,
  output logic [LINES_W-1:0] out_lines_waiting
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  clib_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  clib_dp #(
    .RING_DEPTH      (RING_DEPTH),
    .TAB_ERASE_REPEAT(TAB_ERASE_REPEAT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_key           (in_key),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data         (out_data),
    .out_last         (out_last),
    .out_lines_waiting(out_lines_waiting)
  );

endmodule

// ----- hdl/clib_checker.sv -----
// Port-level checker for the console line input buffer, bound to the top level.
module clib_checker import clib_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [KIND_W-1:0]  out_kind,
  input logic [KEY_W-1:0]   out_data,
  input logic               out_last,
  input logic [LINES_W-1:0] out_lines_waiting
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_data)
      && $stable(out_last) && $stable(out_lines_waiting))
    else $error("stalled result beat changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ECHO || out_kind == KIND_DATA
      || out_kind == KIND_NOT_READY))
    else $error("illegal result kind");

  // A read always answers with a single beat.
  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DATA || out_kind == KIND_NOT_READY) |-> out_last)
    else $error("read result not marked last");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NOT_READY |-> out_data == '0)
    else $error("not-ready result carries data");

  // The block is busy for at least the execute cycle after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

endmodule

bind console_line_input_buffer clib_checker u_clib_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_data         (out_data),
  .out_last         (out_last),
  .out_lines_waiting(out_lines_waiting)
);

// ----- bench/console_line_input_buffer_tb.sv -----
// Self-checking testbench for the console line input buffer: echo, erase, line and raw reads.
module console_line_input_buffer_tb;
  import clib_pkg::*;

  localparam int RING_DEPTH    = 4096;
  localparam int TAB_REPEAT    = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int BATCH_ITEMS   = 70;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   data;
    logic               last;
    logic [LINES_W-1:0] lines;
  } result_beat_t;

  class console_echo_scoreboard;
    logic [KEY_W-1:0] ring [RING_DEPTH];
    int               rd_ptr;
    int               wr_ptr;
    int               lines_held;
    bit               echo_on;
    bit               line_mode;
    result_beat_t     step [$];
    result_beat_t     expected [$];
    int               effective_items;
    int               errors;

    function new();
      rd_ptr          = 0;
      wr_ptr          = 0;
      lines_held      = 0;
      echo_on         = 1'b1;
      line_mode       = 1'b1;
      effective_items = 0;
      errors          = 0;
    endfunction

    function void write_reg(logic idx, logic val);
      if (idx == REG_ECHO_ENABLE) begin
        echo_on = val;
      end else begin
        line_mode  = val;
        rd_ptr     = 0;
        wr_ptr     = 0;
        lines_held = 0;
      end
    endfunction

    function void add_beat(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] data);
      result_beat_t beat;
      beat.kind  = kind;
      beat.data  = data;
      beat.last  = 1'b0;
      beat.lines = '0;
      step.push_back(beat);
    endfunction

    // Work out the beats one accepted item causes and queue them.
    function void note_item(logic op, logic [KEY_W-1:0] key);
      result_beat_t     beat;
      int               prev;
      int               reps;
      logic [KEY_W-1:0] head;
      bit               changed;
      changed = 1'b0;
      step.delete();
      if (op == OP_READ) begin
        if (rd_ptr == wr_ptr || (line_mode && lines_held == 0)) begin
          add_beat(KIND_NOT_READY, '0);
        end else begin
          head = ring[rd_ptr];
          if (line_mode && head == CH_NL) lines_held--;
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          add_beat(KIND_DATA, head);
        end
      end else if (key == CH_BS && echo_on) begin
        prev = (wr_ptr + RING_DEPTH - 1) % RING_DEPTH;
        if (rd_ptr != wr_ptr && ring[prev] != CH_NL) begin
          // a tab gets the full erase sequence repeated, but only one slot goes
          reps    = (ring[prev] == CH_TAB) ? TAB_REPEAT : 1;
          wr_ptr  = prev;
          changed = 1'b1;
          repeat (reps) begin
            add_beat(KIND_ECHO, CH_BS);
            add_beat(KIND_ECHO, CH_SP);
            add_beat(KIND_ECHO, CH_BS);
          end
        end
      end else if ((wr_ptr + 1) % RING_DEPTH != rd_ptr &&
                   ((wr_ptr + 2) % RING_DEPTH != rd_ptr || key == CH_NL)) begin
        if (echo_on) add_beat(KIND_ECHO, key);
        ring[wr_ptr] = key;
        wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
        if (line_mode && key == CH_NL) lines_held++;
        changed = 1'b1;
      end
      if (changed || step.size() != 0) effective_items++;
      foreach (step[i]) begin
        beat       = step[i];
        beat.last  = (i == step.size() - 1);
        beat.lines = (lines_held > LINES_MAX) ? LINES_MAX : LINES_W'(lines_held);
        expected.push_back(beat);
      end
    endfunction

    task report_mismatch(string msg);
      // keep the log short when the block is badly broken
      if (errors < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] data, logic last,
                      logic [LINES_W-1:0] lines);
      result_beat_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d data=%02h", kind, data));
        return;
      end
      want = expected.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (data !== want.data)
        report_mismatch($sformatf("data %02h, want %02h", data, want.data));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      if (lines !== want.lines)
        report_mismatch($sformatf("lines_waiting %0d, want %0d", lines, want.lines));
    endtask

    task flag_leftovers();
      if (expected.size() != 0)
        report_mismatch($sformatf("%0d beats never arrived", expected.size()));
    endtask
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic               cfg_index = REG_ECHO_ENABLE;
  logic               cfg_data  = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               in_op     = OP_PRESS;
  logic [KEY_W-1:0]   in_key    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  out_kind;
  logic [KEY_W-1:0]   out_data;
  logic               out_last;
  logic [LINES_W-1:0] out_lines_waiting;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  console_echo_scoreboard sb = new();

  console_line_input_buffer #(
    .RING_DEPTH       (RING_DEPTH),
    .TAB_ERASE_REPEAT (TAB_REPEAT)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data          (out_data),
    .out_last          (out_last),
    .out_lines_waiting (out_lines_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_kind, out_data, out_last, out_lines_waiting);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("console_line_input_buffer regression: fail");
      $finish;
    end
  end

  // Present one beat, hold it until accepted; valid stays high for a following beat.
  task send_item(logic op, logic [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, key);
  endtask

  // Drop valid and wait until every queued beat is out and the block has gone quiet.
  task settle();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic idx, logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly typed lines with edits, mixed with reads; a share of arbitrary bytes.
  task run_edit_batch(int count);
    int start;
    int pick;
    start = sb.effective_items;
    while (sb.effective_items - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 38)      send_item(OP_PRESS, KEY_W'($urandom_range(8'h20, 8'h7E)));
      else if (pick < 45) send_item(OP_PRESS, KEY_W'($urandom_range(0, 255)));
      else if (pick < 55) send_item(OP_PRESS, CH_BS);
      else if (pick < 62) send_item(OP_PRESS, CH_TAB);
      else if (pick < 73) send_item(OP_PRESS, CH_NL);
      else                send_item(OP_READ, KEY_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bit seg_echo [6];
    bit seg_line [6];
    seg_echo = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    seg_line = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // line mode, echo on: edits, tab erase, erase stops at newline
    send_item(OP_PRESS, 8'h61);
    send_item(OP_PRESS, 8'h00);
    send_item(OP_PRESS, 8'hFF);
    send_item(OP_PRESS, CH_TAB);
    send_item(OP_PRESS, CH_BS);
    send_item(OP_PRESS, CH_BS);
    send_item(OP_PRESS, CH_NL);
    send_item(OP_PRESS, CH_BS);
    repeat (4) send_item(OP_READ, 8'hFF);
    send_item(OP_PRESS, 8'h62);
    send_item(OP_READ, 8'h00);
    send_item(OP_PRESS, CH_BS);
    send_item(OP_PRESS, CH_BS);
    settle();
    // echo off: backspace is stored as data
    write_reg(REG_ECHO_ENABLE, 1'b0);
    send_item(OP_PRESS, CH_BS);
    send_item(OP_PRESS, CH_NL);
    send_item(OP_READ, 8'h00);
    send_item(OP_READ, 8'h00);
    settle();
    // raw mode: newline is plain data
    write_reg(REG_LINE_MODE, 1'b0);
    write_reg(REG_ECHO_ENABLE, 1'b1);
    send_item(OP_PRESS, CH_NL);
    send_item(OP_READ, 8'h00);
    send_item(OP_READ, 8'h00);

    for (int seg = 0; seg < 6; seg++) begin
      settle();
      send_idle_pct = (seg < 2) ? 22 : (seg < 4) ? 62 : 0;
      recv_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 22 : 0;
      write_reg(REG_ECHO_ENABLE, seg_echo[seg]);
      write_reg(REG_LINE_MODE, seg_line[seg]);
      run_edit_batch(BATCH_ITEMS);
    end

    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("console_line_input_buffer regression: pass");
    end else begin
      $display("console_line_input_buffer regression: fail");
    end
    $finish;
  end

endmodule

// ----- console_line_input_buffer.f -----
hdl/clib_pkg.sv
hdl/clib_ram.sv
hdl/clib_ctrl.sv
hdl/clib_dp.sv
hdl/console_line_input_buffer.sv
hdl/clib_checker.sv
bench/console_line_input_buffer_tb.sv
